[design/cbs_pkg.sv]
// shared types, constants and tables of the cubic b-spline curve stream
package cbs_pkg;

    localparam int OUT_W      = 18;   // curve sample width
    localparam int CFG_W      = 5;    // samples-per-segment register width
    localparam int T_W        = 17;   // q1.16 curve parameter, room for 1.0
    localparam int W_W        = 16;   // q0.16 basis weight
    localparam int X_W        = 19;   // weight numerator scaled by 2^-32
    localparam int DIV6_SHIFT = 20;

    localparam logic [T_W-1:0]   T_ONE      = 17'd65536;
    localparam logic [CFG_W-1:0] CFG_RESET  = 5'd8;
    // ceil(2^20 / 6): exact floor division by six for values below 2^19
    localparam logic [18:0]      DIV6_RECIP = 19'd174763;

    typedef struct packed {
        logic           start;
        logic [T_W-1:0] t;
    } t_smp_req;

    // round(65536 / o), o = 0 and o = 1 both give 1.0
    function automatic logic [T_W-1:0] recip_q16(input logic [CFG_W-1:0] o);
        logic [T_W-1:0] r;
        case (o)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd32768;
            5'd3:    r = 17'd21845;
            5'd4:    r = 17'd16384;
            5'd5:    r = 17'd13107;
            5'd6:    r = 17'd10923;
            5'd7:    r = 17'd9362;
            5'd8:    r = 17'd8192;
            5'd9:    r = 17'd7282;
            5'd10:   r = 17'd6554;
            5'd11:   r = 17'd5958;
            5'd12:   r = 17'd5461;
            5'd13:   r = 17'd5041;
            5'd14:   r = 17'd4681;
            5'd15:   r = 17'd4369;
            5'd16:   r = 17'd4096;
            5'd17:   r = 17'd3855;
            5'd18:   r = 17'd3641;
            5'd19:   r = 17'd3449;
            5'd20:   r = 17'd3277;
            5'd21:   r = 17'd3121;
            5'd22:   r = 17'd2979;
            5'd23:   r = 17'd2849;
            5'd24:   r = 17'd2731;
            5'd25:   r = 17'd2621;
            5'd26:   r = 17'd2521;
            5'd27:   r = 17'd2427;
            5'd28:   r = 17'd2341;
            5'd29:   r = 17'd2260;
            5'd30:   r = 17'd2185;
            5'd31:   r = 17'd2114;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

[design/cbs_sample_unit.sv]
// one curve sample: basis weights and weighted sum on a single shared multiplier
module cbs_sample_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cbs_pkg::t_smp_req                  i_req,
    input  logic signed [COORD_BITS+1:0]       i_seg_x [4],
    input  logic signed [COORD_BITS+1:0]       i_seg_y [4],
    output logic                               o_done,
    output logic signed [cbs_pkg::OUT_W-1:0]   o_curve_x,
    output logic signed [cbs_pkg::OUT_W-1:0]   o_curve_y
);
    import cbs_pkg::*;

    localparam int PW    = COORD_BITS + 2;
    localparam int MA    = 34;
    localparam int MB    = (PW > 20) ? PW : 20;
    localparam int PRW   = MA + MB;
    localparam int ACC_W = PW + W_W + 3;
    localparam int RW    = (ACC_W > OUT_W + 16) ? ACC_W : OUT_W + 16;

    localparam logic [4:0] SS_IDLE   = 5'd0;
    localparam logic [4:0] SS_SQR_T  = 5'd1;
    localparam logic [4:0] SS_SQR_S  = 5'd2;
    localparam logic [4:0] SS_CUBE_T = 5'd3;
    localparam logic [4:0] SS_T2S    = 5'd4;
    localparam logic [4:0] SS_CUBE_S = 5'd5;
    localparam logic [4:0] SS_SUM_M  = 5'd6;
    localparam logic [4:0] SS_DIV_W1 = 5'd7;
    localparam logic [4:0] SS_DIV_W3 = 5'd8;
    localparam logic [4:0] SS_DIV_W2 = 5'd9;
    localparam logic [4:0] SS_MAC_X0 = 5'd10;
    localparam logic [4:0] SS_MAC_X1 = 5'd11;
    localparam logic [4:0] SS_MAC_X2 = 5'd12;
    localparam logic [4:0] SS_MAC_X3 = 5'd13;
    localparam logic [4:0] SS_MAC_Y0 = 5'd14;
    localparam logic [4:0] SS_MAC_Y1 = 5'd15;
    localparam logic [4:0] SS_MAC_Y2 = 5'd16;
    localparam logic [4:0] SS_MAC_Y3 = 5'd17;
    localparam logic [4:0] SS_FIN    = 5'd18;

    logic [4:0]               r_step, n_step;
    logic                     r_done;
    logic [T_W-1:0]           r_t, r_s;
    logic signed [PRW-1:0]    r_prod;
    logic signed [MA-1:0]     mul_a;
    logic signed [MB-1:0]     mul_b;
    logic signed [PRW-1:0]    mul_p;
    logic [31:0]              r_t2;
    logic [32:0]              r_s2;
    logic [47:0]              r_m;
    logic [49:0]              r_m3, r_p;
    logic [51:0]              r_p3;
    logic [52:0]              p3_ceil;
    logic [X_W-1:0]           r_x1, r_x2, r_x3, r_x4;
    logic [W_W-1:0]           r_w [4];
    logic signed [ACC_W-1:0]  r_acc_x, r_acc_y;
    logic signed [RW-1:0]     rnd_x, rnd_y;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            SS_SQR_T:  begin mul_a = MA'(r_t);        mul_b = MB'(r_t);        end
            SS_SQR_S:  begin mul_a = MA'(r_s);        mul_b = MB'(r_s);        end
            SS_CUBE_T: begin mul_a = MA'(r_t2);       mul_b = MB'(r_t);        end
            SS_T2S:    begin mul_a = MA'(r_t2);       mul_b = MB'(r_s);        end
            SS_CUBE_S: begin mul_a = MA'(r_s2);       mul_b = MB'(r_s);        end
            SS_SUM_M:  begin mul_a = MA'(r_x4);       mul_b = MB'(DIV6_RECIP); end
            SS_DIV_W1: begin mul_a = MA'(r_x1);       mul_b = MB'(DIV6_RECIP); end
            SS_DIV_W3: begin mul_a = MA'(r_x3);       mul_b = MB'(DIV6_RECIP); end
            SS_DIV_W2: begin mul_a = MA'(r_x2);       mul_b = MB'(DIV6_RECIP); end
            SS_MAC_X0: begin mul_a = MA'(r_w[0]);     mul_b = MB'(i_seg_x[0]); end
            SS_MAC_X1: begin mul_a = MA'(r_w[1]);     mul_b = MB'(i_seg_x[1]); end
            SS_MAC_X2: begin mul_a = MA'(r_w[2]);     mul_b = MB'(i_seg_x[2]); end
            SS_MAC_X3: begin mul_a = MA'(r_w[3]);     mul_b = MB'(i_seg_x[3]); end
            SS_MAC_Y0: begin mul_a = MA'(r_w[0]);     mul_b = MB'(i_seg_y[0]); end
            SS_MAC_Y1: begin mul_a = MA'(r_w[1]);     mul_b = MB'(i_seg_y[1]); end
            SS_MAC_Y2: begin mul_a = MA'(r_w[2]);     mul_b = MB'(i_seg_y[2]); end
            SS_MAC_Y3: begin mul_a = MA'(r_w[3]);     mul_b = MB'(i_seg_y[3]); end
            default:   begin mul_a = '0;              mul_b = '0;              end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ceil(3p / 2^32) for the second weight
    assign p3_ceil = 53'(r_p3) + 53'(33'h0_FFFF_FFFF);

    always_comb begin
        case (r_step)
            SS_IDLE: n_step = i_req.start ? SS_SQR_T : SS_IDLE;
            SS_FIN:  n_step = SS_IDLE;
            default: n_step = r_step + 5'd1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= SS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= (r_step == SS_FIN);
        end
    end

    // product of the previous slot is consumed while the next one is issued
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_step)
            SS_IDLE: begin
                r_t <= i_req.t;
                r_s <= T_ONE - i_req.t;
            end
            SS_SQR_S: r_t2 <= r_prod[31:0];
            SS_CUBE_T: r_s2 <= r_prod[32:0];
            SS_T2S: r_x4 <= X_W'(r_prod[47:32]) + X_W'(3);
            SS_CUBE_S: r_m <= r_prod[47:0];
            SS_SUM_M: begin
                r_x1 <= X_W'(r_prod[48:32]) + X_W'(3);
                r_m3 <= 50'({r_m, 1'b0}) + 50'(r_m);
                r_p  <= 50'(r_m) + 50'({r_t2, 16'd0});
            end
            SS_DIV_W1: begin
                r_w[3] <= r_prod[DIV6_SHIFT +: W_W];
                r_x3   <= X_W'(r_m3[49:32]) + X_W'({r_t, 1'b0}) + X_W'(r_t) + X_W'(65539);
                r_p3   <= 52'({r_p, 1'b0}) + 52'(r_p);
            end
            SS_DIV_W3: begin
                r_w[0] <= r_prod[DIV6_SHIFT +: W_W];
                r_x2   <= X_W'(262147) - X_W'(p3_ceil[52:32]);
            end
            SS_DIV_W2: r_w[2] <= r_prod[DIV6_SHIFT +: W_W];
            SS_MAC_X0: r_w[1] <= r_prod[DIV6_SHIFT +: W_W];
            SS_MAC_X1: r_acc_x <= ACC_W'(r_prod);
            SS_MAC_X2: r_acc_x <= r_acc_x + ACC_W'(r_prod);
            SS_MAC_X3: r_acc_x <= r_acc_x + ACC_W'(r_prod);
            SS_MAC_Y0: r_acc_x <= r_acc_x + ACC_W'(r_prod);
            SS_MAC_Y1: r_acc_y <= ACC_W'(r_prod);
            SS_MAC_Y2: r_acc_y <= r_acc_y + ACC_W'(r_prod);
            SS_MAC_Y3: r_acc_y <= r_acc_y + ACC_W'(r_prod);
            SS_FIN:    r_acc_y <= r_acc_y + ACC_W'(r_prod);
            default: ;
        endcase
    end

    // round half up out of q16, then wrap to the output width
    assign rnd_x = (RW'(r_acc_x) + RW'(32768)) >>> 16;
    assign rnd_y = (RW'(r_acc_y) + RW'(32768)) >>> 16;

    assign o_done    = r_done;
    assign o_curve_x = rnd_x[OUT_W-1:0];
    assign o_curve_y = rnd_y[OUT_W-1:0];

endmodule

[design/cubic_b_spline_curve_stream_unit.sv]
// top level of the uniform cubic b-spline curve stream
//
//  channel   direction  handshake                  payload
//  ------    ---------  -------------------------  ------------------------------------
//  config    in         i_cfg_valid / o_cfg_ready  i_points_per_segment
//  points    in         i_valid / o_ready          i_point_x, i_point_y, i_last_point
//  curve     out        o_valid / i_ready          o_curve_x, o_curve_y, o_curve_end
//
//  a curve sample runs through the start, 17 shared-multiplier slots (cubes, four divisions
//  by six, eight weighted products), a drain slot and the hand-off
//  a point is held while its segments run (one inside a curve, up to two for the closing
//  point); the first two points and a lone point run none; o_ready is low meanwhile
//  synchronous active-low reset clears control, r_seen and loads o = 8; no clearing pass
//  a stalled output holds the sequencer at the sample hand-off, no result is dropped
module cubic_b_spline_curve_stream_unit #(
    parameter int COORD_BITS         = 16,
    parameter int MAX_SEGMENT_POINTS = 31
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cbs_pkg::CFG_W-1:0]            i_points_per_segment,
    // control points
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [COORD_BITS-1:0]         i_point_x,
    input  logic signed [COORD_BITS-1:0]         i_point_y,
    input  logic                                 i_last_point,
    // curve samples
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [cbs_pkg::OUT_W-1:0]     o_curve_x,
    output logic signed [cbs_pkg::OUT_W-1:0]     o_curve_y,
    output logic                                 o_curve_end
);
    import cbs_pkg::*;

    localparam int PW = COORD_BITS + 2;                           // room for reflected points
    localparam int EW = (COORD_BITS > OUT_W) ? COORD_BITS : OUT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a point
    localparam logic [1:0] ST_RUN  = 2'd1;   // sample unit busy
    localparam logic [1:0] ST_EMIT = 2'd2;   // sample ready, output register full
    localparam logic [1:0] ST_END  = 2'd3;   // closing exact point

    // reflected phantom point 2a - b
    function automatic logic signed [PW-1:0] reflect(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        return (PW'(a) <<< 1) - PW'(b);
    endfunction

    logic [1:0]                     r_state;
    logic [CFG_W-1:0]               r_cfg;
    logic [1:0]                     r_seen;
    logic                           r_start;
    logic                           r_seg2;     // final segment still to run
    logic                           r_last;     // closing point still to send
    logic                           r_out_valid;
    logic signed [OUT_W-1:0]        r_out_x, r_out_y;
    logic                           r_out_end;

    logic signed [COORD_BITS-1:0]   r_win_x [3];
    logic signed [COORD_BITS-1:0]   r_win_y [3];
    logic signed [COORD_BITS-1:0]   r_nx, r_ny;
    logic signed [PW-1:0]           r_seg_x [4];
    logic signed [PW-1:0]           r_seg_y [4];
    logic signed [PW-1:0]           r_nxt_x [4];
    logic signed [PW-1:0]           r_nxt_y [4];
    logic [CFG_W-1:0]               r_o, r_k;
    logic [T_W-1:0]                 r_t, r_rec;

    logic [CFG_W-1:0]               o_eff;
    logic signed [PW-1:0]           n_seg1_x [4];
    logic signed [PW-1:0]           n_seg1_y [4];
    logic signed [PW-1:0]           n_seg2_x [4];
    logic signed [PW-1:0]           n_seg2_y [4];
    logic                           acc_in, out_free, emit_smp, emit_end, seg_done;
    logic                           seen_ge1, seen_ge2, start_in;
    logic signed [EW-1:0]           end_x, end_y;

    t_smp_req                       smp_req;
    logic                           smp_done;
    logic signed [OUT_W-1:0]        smp_x, smp_y;

    // samples per segment: zero acts as one, large values clip
    always_comb begin
        if (r_cfg == '0) begin
            o_eff = CFG_W'(1);
        end else if (r_cfg > CFG_W'(MAX_SEGMENT_POINTS)) begin
            o_eff = CFG_W'(MAX_SEGMENT_POINTS);
        end else begin
            o_eff = r_cfg;
        end
    end

    assign seen_ge1 = |r_seen;
    assign seen_ge2 = r_seen[1];

    // segment ending at the new point; head is reflected for the third point
    assign n_seg1_x[0] = (r_seen == 2'd2) ? reflect(r_win_x[1], r_win_x[2]) : PW'(r_win_x[0]);
    assign n_seg1_y[0] = (r_seen == 2'd2) ? reflect(r_win_y[1], r_win_y[2]) : PW'(r_win_y[0]);
    assign n_seg1_x[1] = PW'(r_win_x[1]);
    assign n_seg1_y[1] = PW'(r_win_y[1]);
    assign n_seg1_x[2] = PW'(r_win_x[2]);
    assign n_seg1_y[2] = PW'(r_win_y[2]);
    assign n_seg1_x[3] = PW'(i_point_x);
    assign n_seg1_y[3] = PW'(i_point_y);

    // closing segment with the reflected tail; two-point curve reflects the head too
    assign n_seg2_x[0] = (r_seen == 2'd1) ? reflect(r_win_x[2], i_point_x) : PW'(r_win_x[1]);
    assign n_seg2_y[0] = (r_seen == 2'd1) ? reflect(r_win_y[2], i_point_y) : PW'(r_win_y[1]);
    assign n_seg2_x[1] = PW'(r_win_x[2]);
    assign n_seg2_y[1] = PW'(r_win_y[2]);
    assign n_seg2_x[2] = PW'(i_point_x);
    assign n_seg2_y[2] = PW'(i_point_y);
    assign n_seg2_x[3] = reflect(i_point_x, r_win_x[2]);
    assign n_seg2_y[3] = reflect(i_point_y, r_win_y[2]);

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign acc_in      = i_valid && o_ready;
    assign start_in    = seen_ge2 || (i_last_point && seen_ge1);

    assign out_free = !r_out_valid || i_ready;
    assign emit_smp = ((r_state == ST_RUN && smp_done) || r_state == ST_EMIT) && out_free;
    assign emit_end = (r_state == ST_END) && out_free;
    assign seg_done = (r_k == r_o - CFG_W'(1));

    assign end_x = EW'(r_nx);
    assign end_y = EW'(r_ny);

    assign smp_req.start = r_start;
    assign smp_req.t     = r_t;

    cbs_sample_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_sample (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (smp_req),
        .i_seg_x   (r_seg_x),
        .i_seg_y   (r_seg_y),
        .o_done    (smp_done),
        .o_curve_x (smp_x),
        .o_curve_y (smp_y)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= CFG_RESET;
            r_seen      <= 2'd0;
            r_start     <= 1'b0;
            r_seg2      <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // one-cycle start pulse: first sample of a point or the next sample
            r_start <= (acc_in && start_in) || (emit_smp && (!seg_done || r_seg2));
            if (i_cfg_valid) begin
                r_cfg <= i_points_per_segment;
            end

            if (emit_smp || emit_end) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (acc_in) begin
                        r_last <= i_last_point;
                        r_seg2 <= seen_ge2 && i_last_point;
                        if (start_in) begin
                            r_state <= ST_RUN;
                        end else if (i_last_point) begin
                            // lone point goes straight out
                            r_state <= ST_END;
                        end
                        if (i_last_point) begin
                            r_seen <= 2'd0;
                        end else if (r_seen != 2'd3) begin
                            r_seen <= r_seen + 2'd1;
                        end
                    end
                end
                ST_RUN, ST_EMIT: begin
                    if (emit_smp) begin
                        if (!seg_done || r_seg2) begin
                            r_state <= ST_RUN;
                            if (seg_done) begin
                                r_seg2 <= 1'b0;
                            end
                        end else if (r_last) begin
                            r_state <= ST_END;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end else if (r_state == ST_RUN && smp_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_END: begin
                    if (emit_end) begin
                        r_last  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_nx  <= i_point_x;
            r_ny  <= i_point_y;
            r_o   <= o_eff;
            r_rec <= recip_q16(o_eff);
            r_k   <= '0;
            r_t   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_seg_x[i] <= seen_ge2 ? n_seg1_x[i] : n_seg2_x[i];
                r_seg_y[i] <= seen_ge2 ? n_seg1_y[i] : n_seg2_y[i];
                r_nxt_x[i] <= n_seg2_x[i];
                r_nxt_y[i] <= n_seg2_y[i];
            end
            if (!i_last_point) begin
                r_win_x[0] <= r_win_x[1];
                r_win_y[0] <= r_win_y[1];
                r_win_x[1] <= r_win_x[2];
                r_win_y[1] <= r_win_y[2];
                r_win_x[2] <= i_point_x;
                r_win_y[2] <= i_point_y;
            end
        end

        if (emit_smp) begin
            r_out_x   <= smp_x;
            r_out_y   <= smp_y;
            r_out_end <= 1'b0;
            if (seg_done) begin
                // next segment restarts at t = 0
                r_k <= '0;
                r_t <= '0;
                for (int i = 0; i < 4; i++) begin
                    r_seg_x[i] <= r_nxt_x[i];
                    r_seg_y[i] <= r_nxt_y[i];
                end
            end else begin
                r_k <= r_k + CFG_W'(1);
                r_t <= r_t + r_rec;
            end
        end else if (emit_end) begin
            r_out_x   <= end_x[OUT_W-1:0];
            r_out_y   <= end_y[OUT_W-1:0];
            r_out_end <= 1'b1;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_curve_x   = r_out_x;
    assign o_curve_y   = r_out_y;
    assign o_curve_end = r_out_end;

endmodule
